FILE: design/ppq_pkg.sv
// ----------------------------------------------------------------------------
// Process priority queue package
// Shared widths, action and status codes, controller states and the
// command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package ppq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int ACTION_W   = 2;
  localparam int HANDLE_W   = 8;
  localparam int PRIORITY_W = 8;
  localparam int INDEX_W    = 6;
  localparam int STATUS_W   = 2;
  localparam int NEXT_W     = 7;
  localparam int OCC_W      = 7;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

  localparam logic REG_PRIORITY_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } ppq_state_t;

  typedef struct packed {
    logic load;
    logic simple;
    logic scan_init;
    logic scan_step;
    logic remove;
    logic head;
  } ppq_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                empty;
    logic                scan_done;
  } ppq_stat_t;

endpackage

FILE: design/ppq_ctrl.sv
// ----------------------------------------------------------------------------
// Process priority queue controller
// Sequences one request: capture, execute, and the priority scan that ends
// in the removal of the selected entry.
// ----------------------------------------------------------------------------
module ppq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               priority_mode,
  input  ppq_pkg::ppq_stat_t stat,
  output ppq_pkg::ppq_cmd_t  cmd,
  output logic               busy
);
  import ppq_pkg::*;

  ppq_state_t state;
  ppq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.action == ACT_DEQUEUE && !stat.empty) begin
          if (priority_mode) begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end else begin
            cmd.remove = 1'b1;
            cmd.head   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.simple = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.remove = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: design/ppq_datapath.sv
// ----------------------------------------------------------------------------
// Process priority queue datapath
// Row of entry cells with tail append and parallel compaction, the
// lowest-priority scan unit, and the result registers.
// ----------------------------------------------------------------------------
module ppq_datapath #(
  parameter int QUEUE_DEPTH = ppq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ppq_pkg::ppq_cmd_t                  cmd,
  output ppq_pkg::ppq_stat_t                 stat,
  input  logic [ppq_pkg::ACTION_W-1:0]       action,
  input  logic [ppq_pkg::HANDLE_W-1:0]       proc_handle,
  input  logic [ppq_pkg::PRIORITY_W-1:0]     proc_priority,
  input  logic [ppq_pkg::INDEX_W-1:0]        read_index,
  output logic                               done,
  output logic [ppq_pkg::STATUS_W-1:0]       status,
  output logic [ppq_pkg::HANDLE_W-1:0]       out_handle,
  output logic [ppq_pkg::PRIORITY_W-1:0]     out_priority,
  output logic [ppq_pkg::NEXT_W-1:0]         next_index,
  output logic [ppq_pkg::OCC_W-1:0]          occupancy,
  output logic                               is_empty
);
  import ppq_pkg::*;

  localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);

  logic [HANDLE_W-1:0]   hdl_cells [QUEUE_DEPTH];
  logic [PRIORITY_W-1:0] pri_cells [QUEUE_DEPTH];
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;

  logic [ACTION_W-1:0]   act;
  logic [HANDLE_W-1:0]   hdl;
  logic [PRIORITY_W-1:0] pri;
  logic [INDEX_W-1:0]    idx;

  logic [CW-1:0]         scan;
  logic [IDXW-1:0]       best;
  logic [PRIORITY_W-1:0] best_pri;

  logic                  full;
  logic                  enq_we;
  logic                  res_we;
  logic [IDXW-1:0]       rem_pos;
  logic [STATUS_W-1:0]   res_status;
  logic [HANDLE_W-1:0]   res_hdl;
  logic [PRIORITY_W-1:0] res_pri;
  logic [NEXT_W-1:0]     res_next;
  logic [PRIORITY_W-1:0] scan_pri;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign rem_pos  = cmd.head ? '0 : best;
  assign scan_pri = pri_cells[scan[IDXW-1:0]];

  assign stat.action    = act;
  assign stat.empty     = (count == '0);
  assign stat.scan_done = (scan >= count);

  always_comb begin
    count_next = count;
    enq_we     = 1'b0;
    res_we     = 1'b0;
    res_status = STAT_OK;
    res_hdl    = '0;
    res_pri    = '0;
    res_next   = {1'b0, idx};
    if (cmd.simple) begin
      res_we = 1'b1;
      unique case (act)
        ACT_ENQUEUE: begin
          if (full) begin
            res_status = STAT_FULL;
          end else begin
            enq_we     = 1'b1;
            count_next = count + 1'b1;
          end
        end
        ACT_DEQUEUE: begin
          res_status = STAT_EMPTY;
        end
        ACT_READ: begin
          if (count == '0) begin
            res_status = STAT_EMPTY;
          end else if ({1'b0, idx} >= NEXT_W'(count)) begin
            res_status = STAT_RANGE;
          end else begin
            res_hdl  = hdl_cells[idx[IDXW-1:0]];
            res_pri  = pri_cells[idx[IDXW-1:0]];
            res_next = {1'b0, idx} + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.remove) begin
      res_we     = 1'b1;
      res_hdl    = hdl_cells[rem_pos];
      res_pri    = pri_cells[rem_pos];
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= res_we;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      hdl <= proc_handle;
      pri <= proc_priority;
      idx <= read_index;
    end
    if (cmd.scan_init) begin
      scan     <= CW'(1);
      best     <= '0;
      best_pri <= pri_cells[0];
    end else if (cmd.scan_step) begin
      scan <= scan + 1'b1;
      if (scan_pri < best_pri) begin
        best     <= scan[IDXW-1:0];
        best_pri <= scan_pri;
      end
    end
    if (res_we) begin
      status       <= res_status;
      out_handle   <= res_hdl;
      out_priority <= res_pri;
      next_index   <= res_next;
      occupancy    <= OCC_W'(count_next);
      is_empty     <= (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.remove) begin
        if (i < QUEUE_DEPTH - 1 && IDXW'(i) >= rem_pos) begin
          hdl_cells[i] <= hdl_cells[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          pri_cells[i] <= pri_cells[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end else if (enq_we && CW'(i) == count) begin
        hdl_cells[i] <= hdl;
        pri_cells[i] <= pri;
      end
    end
  end

endmodule

FILE: design/process_priority_queue.sv
// ----------------------------------------------------------------------------
// Process priority queue
// Bounded ready queue of process handles with FIFO or lowest-priority
// dequeue, read at index, and an APB-style mode register.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. Enqueue, read,
// FIFO dequeue and every request that fails or does nothing pass through the
// capture and execute states before the next acceptance; a priority dequeue
// adds the scan state, where the scan unit visits one stored entry per cycle.
// Each result appears for exactly one cycle with done high and cannot be
// held off, so the receiver must take it in that cycle. A new request may be
// accepted in the same cycle that a result is shown.
module process_priority_queue #(
  parameter int QUEUE_DEPTH = ppq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ppq_pkg::ACTION_W-1:0]       action,
  input  logic [ppq_pkg::HANDLE_W-1:0]       proc_handle,
  input  logic [ppq_pkg::PRIORITY_W-1:0]     proc_priority,
  input  logic [ppq_pkg::INDEX_W-1:0]        read_index,
  output logic                               done,
  output logic [ppq_pkg::STATUS_W-1:0]       status,
  output logic [ppq_pkg::HANDLE_W-1:0]       out_handle,
  output logic [ppq_pkg::PRIORITY_W-1:0]     out_priority,
  output logic [ppq_pkg::NEXT_W-1:0]         next_index,
  output logic [ppq_pkg::OCC_W-1:0]          occupancy,
  output logic                               is_empty,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppq_pkg::PADDR_W-1:0]        paddr,
  input  logic [ppq_pkg::PDATA_W-1:0]        pwdata,
  output logic [ppq_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import ppq_pkg::*;

  logic      priority_mode;
  ppq_cmd_t  cmd;
  ppq_stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PRIORITY_MODE) begin
      priority_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_PRIORITY_MODE) ? {{(PDATA_W-1){1'b0}}, priority_mode}
                                                  : '0;

  ppq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .priority_mode (priority_mode),
    .stat          (stat),
    .cmd           (cmd),
    .busy          (busy)
  );

  ppq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .proc_handle   (proc_handle),
    .proc_priority (proc_priority),
    .read_index    (read_index),
    .done          (done),
    .status        (status),
    .out_handle    (out_handle),
    .out_priority  (out_priority),
    .next_index    (next_index),
    .occupancy     (occupancy),
    .is_empty      (is_empty)
  );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// Process priority queue testbench
// Drives enqueue, dequeue and read requests through the start/busy handshake,
// with bursts and random gaps. A shadow copy of the ready queue predicts each
// result, and every done strobe is checked field by field. The mode register
// is set over APB between phases, in both FIFO and priority order.
// ----------------------------------------------------------------------------
module testbench;

  import ppq_pkg::*;

  localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [ACTION_W-1:0]   action;
    logic [HANDLE_W-1:0]   handle;
    logic [PRIORITY_W-1:0] prio;
    logic [INDEX_W-1:0]    index;
  } queue_request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [HANDLE_W-1:0]   handle;
    logic [PRIORITY_W-1:0] prio;
    logic [NEXT_W-1:0]     next_index;
    logic [OCC_W-1:0]      occupancy;
    logic                  is_empty;
  } queue_result_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ACTION_W-1:0]   action = ACT_ENQUEUE;
  logic [HANDLE_W-1:0]   proc_handle = '0;
  logic [PRIORITY_W-1:0] proc_priority = '0;
  logic [INDEX_W-1:0]    read_index = '0;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic [HANDLE_W-1:0]   out_handle;
  logic [PRIORITY_W-1:0] out_priority;
  logic [NEXT_W-1:0]     next_index;
  logic [OCC_W-1:0]      occupancy;
  logic                  is_empty;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  process_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .proc_handle(proc_handle), .proc_priority(proc_priority),
    .read_index(read_index), .done(done), .status(status),
    .out_handle(out_handle), .out_priority(out_priority),
    .next_index(next_index), .occupancy(occupancy), .is_empty(is_empty),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  queue_request_t request_backlog[$];
  queue_result_t  expected_results[$];
  queue_request_t current_request;

  logic [HANDLE_W-1:0]   shadow_handles[QUEUE_DEPTH];
  logic [PRIORITY_W-1:0] shadow_priorities[QUEUE_DEPTH];
  int                    shadow_count = 0;
  logic                  dequeue_by_priority = 1'b0;
  int                    planned_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int requests_done = 0;
  int results_seen = 0;
  int full_drops = 0;
  int empty_hits = 0;
  int range_hits = 0;
  int priority_dequeues = 0;
  int phases_run = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic queue_result_t ready_queue_step(input queue_request_t req);
    queue_result_t res;
    int            best;
    res = '0;
    res.next_index = NEXT_W'(req.index);
    if (req.action == ACT_ENQUEUE) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        res.status = STAT_FULL;
        full_drops++;
      end else begin
        shadow_handles[shadow_count] = req.handle;
        shadow_priorities[shadow_count] = req.prio;
        shadow_count++;
      end
    end else if (req.action == ACT_DEQUEUE) begin
      if (shadow_count == 0) begin
        res.status = STAT_EMPTY;
        empty_hits++;
      end else begin
        best = 0;
        if (dequeue_by_priority) begin
          priority_dequeues++;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_priorities[i] < shadow_priorities[best]) begin
              best = i;
            end
          end
        end
        res.handle = shadow_handles[best];
        res.prio = shadow_priorities[best];
        for (int i = best; i + 1 < shadow_count; i++) begin
          shadow_handles[i] = shadow_handles[i + 1];
          shadow_priorities[i] = shadow_priorities[i + 1];
        end
        shadow_count--;
      end
    end else if (req.action == ACT_READ) begin
      if (shadow_count == 0) begin
        res.status = STAT_EMPTY;
        empty_hits++;
      end else if (int'(req.index) >= shadow_count) begin
        res.status = STAT_RANGE;
        range_hits++;
      end else begin
        res.handle = shadow_handles[int'(req.index)];
        res.prio = shadow_priorities[int'(req.index)];
        res.next_index = NEXT_W'(req.index) + 1'b1;
      end
    end
    res.occupancy = OCC_W'(shadow_count);
    res.is_empty = (shadow_count == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(ready_queue_step(current_request));
        requests_done++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          current_request = request_backlog.pop_front();
          action <= current_request.action;
          proc_handle <= current_request.handle;
          proc_priority <= current_request.prio;
          read_index <= current_request.index;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("out_handle", 32'(want.handle), 32'(out_handle));
        check_field("out_priority", 32'(want.prio), 32'(out_priority));
        check_field("next_index", 32'(want.next_index), 32'(next_index));
        check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
        check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("process_priority_queue: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_request(input logic [ACTION_W-1:0] act,
                             input logic [HANDLE_W-1:0] handle,
                             input logic [PRIORITY_W-1:0] prio,
                             input logic [INDEX_W-1:0] index);
    request_backlog.push_back('{act, handle, prio, index});
    if (act == ACT_ENQUEUE && planned_count < QUEUE_DEPTH) begin
      planned_count++;
    end else if (act == ACT_DEQUEUE && planned_count > 0) begin
      planned_count--;
    end
  endtask

  function automatic logic [PRIORITY_W-1:0] random_priority();
    return ($urandom_range(0, 1) == 1) ? PRIORITY_W'($urandom_range(0, 3))
                                        : PRIORITY_W'($urandom);
  endfunction

  task automatic add_random_requests(input int n);
    int                  enqueue_weight;
    int                  pick;
    logic [INDEX_W-1:0]  index;
    logic [ACTION_W-1:0] act;
    enqueue_weight = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 24 == 0) begin
        enqueue_weight = $urandom_range(10, 90);
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        act = ACT_UNUSED;
      end else if (pick < 20) begin
        act = ACT_READ;
      end else if ($urandom_range(0, 99) < enqueue_weight) begin
        act = ACT_ENQUEUE;
      end else begin
        act = ACT_DEQUEUE;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6 && planned_count > 0) begin
        index = INDEX_W'($urandom_range(0, planned_count - 1));
      end else if (pick < 8) begin
        index = INDEX_W'(planned_count);
      end else begin
        index = INDEX_W'($urandom_range(0, 63));
      end
      add_request(act, HANDLE_W'($urandom), random_priority(), index);
    end
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * REG_PRIORITY_MODE);
    pwdata <= PDATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dequeue_by_priority = mode;
  endtask

  task automatic wait_until_idle();
    while (request_backlog.size() > 0 || start || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    phases_run++;
  endtask

  initial begin
    logic phase_modes[6];
    phase_modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    add_request(ACT_DEQUEUE, 8'h00, 8'h00, 6'd0);
    add_request(ACT_READ, 8'hFF, 8'hFF, 6'd0);
    add_request(ACT_READ, 8'h00, 8'h00, 6'd63);
    add_request(ACT_UNUSED, 8'hFF, 8'hFF, 6'd63);
    add_request(ACT_ENQUEUE, 8'h00, 8'hFF, 6'd0);
    add_request(ACT_ENQUEUE, 8'hFF, 8'h00, 6'd63);
    for (int k = 2; k < QUEUE_DEPTH; k++) begin
      add_request(ACT_ENQUEUE, HANDLE_W'($urandom), random_priority(), 6'd0);
    end
    add_request(ACT_ENQUEUE, 8'hA5, 8'h5A, 6'd0);
    add_request(ACT_READ, 8'h00, 8'h00, 6'd0);
    add_request(ACT_READ, 8'h00, 8'h00, INDEX_W'(QUEUE_DEPTH - 1));
    add_request(ACT_READ, 8'h00, 8'h00, INDEX_W'(QUEUE_DEPTH));
    add_request(ACT_READ, 8'h00, 8'h00, 6'd63);
    add_request(ACT_DEQUEUE, 8'h00, 8'h00, 6'd0);
    wait_until_idle();

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      add_random_requests(240);
      wait_until_idle();
    end

    $display("Ran %0d requests over %0d phases in both dequeue orders; %0d results.",
             requests_done, phases_run, results_seen);
    $display("Saw %0d full drops, %0d empty, %0d out of range, %0d priority dequeues.",
             full_drops, empty_hits, range_hits, priority_dequeues);
    if (mismatches == 0) begin
      $display("process_priority_queue: match");
    end else begin
      $display("process_priority_queue: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ppq_pkg.sv
design/ppq_ctrl.sv
design/ppq_datapath.sv
design/process_priority_queue.sv
bench/testbench.sv
